// ===== rtl/core/madp_pkg.sv =====
package madp_pkg;

  localparam int TH_BITS = 16;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LUMA_LOW    = 3'd0,
    CFG_LUMA_HIGH   = 3'd1,
    CFG_CHROMA_LOW  = 3'd2,
    CFG_CHROMA_HIGH = 3'd3,
    CFG_ELA_ENABLE  = 3'd4
  } cfg_reg_t;

  typedef logic [1:0] row_pos_t;
  localparam row_pos_t ROW_TOP    = 2'd1;
  localparam row_pos_t ROW_BOTTOM = 2'd2;

  // One division request moving down the divider stages.
  typedef struct packed {
    logic valid;
    logic en;
  } div_ctrl_t;

endpackage

// ===== rtl/core/motion_adaptive_deinterlace_pixel_top.sv =====
// Throughput: one pixel per cycle; the blend division takes one quotient bit
// per pipeline stage, so its depth sets the latency.
// A stalled output freezes the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and loads the
// threshold and ELA enable registers with their defaults.
module motion_adaptive_deinterlace_pixel_top #(
  parameter int PIXEL_BITS = 16,
  parameter int ELA_TAPS   = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_above_center,
  input  logic [15:0] in_below_center,
  input  logic [63:0] in_above_sides,
  input  logic [63:0] in_below_sides,
  input  logic [31:0] in_prev_pair,
  input  logic [31:0] in_next_pair,
  input  logic [15:0] in_cur_pixel,
  input  logic [15:0] in_adjacent_pixel,
  input  logic [1:0]  in_row_position,
  input  logic        in_ela_allowed,
  input  logic        in_is_chroma,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [madp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int P     = PIXEL_BITS;
  localparam int TH_W  = madp_pkg::TH_BITS;
  localparam int NUM_W = TH_W + P;
  localparam int HALF  = (ELA_TAPS - 1) / 2;

  // Configuration registers
  logic [TH_W-1:0] luma_low_r, luma_high_r, chroma_low_r, chroma_high_r;
  logic            ela_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_low_r    <= 16'd7;
      luma_high_r   <= 16'd12;
      chroma_low_r  <= 16'd5;
      chroma_high_r <= 16'd7;
      ela_enable_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (madp_pkg::cfg_reg_t'(cfg_index))
        madp_pkg::CFG_LUMA_LOW:    luma_low_r    <= cfg_data;
        madp_pkg::CFG_LUMA_HIGH:   luma_high_r   <= cfg_data;
        madp_pkg::CFG_CHROMA_LOW:  chroma_low_r  <= cfg_data;
        madp_pkg::CFG_CHROMA_HIGH: chroma_high_r <= cfg_data;
        madp_pkg::CFG_ELA_ENABLE:  ela_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic div_valid;
  logic [P-1:0] div_quot;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: differences, sums, tap scores
  logic [P-1:0] up [5];
  logic [P-1:0] dn [5];
  logic [P-1:0] a, b, pa, pb, na, nb, cur, adj;
  logic [P-1:0] sc_nxt [ELA_TAPS];
  logic [P-1:0] pt_nxt [ELA_TAPS];
  logic [P:0]   sum_t;

  function automatic logic [P-1:0] absdiff(input logic [P-1:0] x, input logic [P-1:0] y);
    absdiff = (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [P-1:0] avg2(input logic [P-1:0] x, input logic [P-1:0] y);
    logic [P:0] s;
    s    = {1'b0, x} + {1'b0, y};
    avg2 = s[P:1];
  endfunction

  always_comb begin
    a   = in_above_center[P-1:0];
    b   = in_below_center[P-1:0];
    pa  = in_prev_pair[P-1:0];
    pb  = in_prev_pair[16+P-1:16];
    na  = in_next_pair[P-1:0];
    nb  = in_next_pair[16+P-1:16];
    cur = in_cur_pixel[P-1:0];
    adj = in_adjacent_pixel[P-1:0];
    up[0] = in_above_sides[P-1:0];
    up[1] = in_above_sides[16+P-1:16];
    up[2] = a;
    up[3] = in_above_sides[32+P-1:32];
    up[4] = in_above_sides[48+P-1:48];
    dn[0] = in_below_sides[P-1:0];
    dn[1] = in_below_sides[16+P-1:16];
    dn[2] = b;
    dn[3] = in_below_sides[32+P-1:32];
    dn[4] = in_below_sides[48+P-1:48];
    for (int i = 0; i < ELA_TAPS; i++) begin
      sc_nxt[i] = absdiff(up[2+i-HALF], dn[2-i+HALF]);
      pt_nxt[i] = avg2(up[2+i-HALF], dn[2-i+HALF]);
    end
    sum_t = '0;
  end

  logic                v1_r;
  logic [P-1:0]        a1_r, b1_r, dpa1_r, dpb1_r, dna1_r, dnb1_r, dac1_r;
  logic [P-1:0]        temp1_r, lavg1_r;
  logic [P-1:0]        sc1_r [ELA_TAPS];
  logic [P-1:0]        pt1_r [ELA_TAPS];
  madp_pkg::row_pos_t  pos1_r;
  logic                ela1_r, chroma1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      a1_r      <= a;
      b1_r      <= b;
      dpa1_r    <= absdiff(a, pa);
      dpb1_r    <= absdiff(b, pb);
      dna1_r    <= absdiff(a, na);
      dnb1_r    <= absdiff(b, nb);
      dac1_r    <= absdiff(adj, cur);
      temp1_r   <= avg2(adj, cur);
      lavg1_r   <= avg2(a, b) | sum_t[P-1:0];
      sc1_r     <= sc_nxt;
      pt1_r     <= pt_nxt;
      pos1_r    <= in_row_position;
      ela1_r    <= ela_enable_r && in_ela_allowed;
      chroma1_r <= in_is_chroma;
    end
  end

  // Stage 2: motion and spatial value
  logic [P-1:0] d1, d2, mx, m_nxt, best_sc, best_pt, sp_nxt;
  logic         betw;

  always_comb begin
    best_sc = sc1_r[0];
    best_pt = pt1_r[0];
    // Strict compare keeps the lowest tap on ties.
    for (int i = 1; i < ELA_TAPS; i++) begin
      if (sc1_r[i] < best_sc) begin
        best_sc = sc1_r[i];
        best_pt = pt1_r[i];
      end
    end
    betw = ((a1_r <= best_pt) && (best_pt <= b1_r)) ||
           ((a1_r >= best_pt) && (best_pt >= b1_r));
    case (pos1_r)
      madp_pkg::ROW_TOP: begin
        d1     = dpb1_r;
        d2     = dnb1_r;
        sp_nxt = b1_r;
      end
      madp_pkg::ROW_BOTTOM: begin
        d1     = dpa1_r;
        d2     = dna1_r;
        sp_nxt = a1_r;
      end
      default: begin
        d1     = avg2(dpa1_r, dpb1_r);
        d2     = avg2(dna1_r, dnb1_r);
        sp_nxt = (ela1_r && betw) ? best_pt : lavg1_r;
      end
    endcase
    mx    = (d1 > d2) ? d1 : d2;
    m_nxt = (mx > dac1_r) ? mx : dac1_r;
  end

  logic            v2_r;
  logic [P-1:0]    m2_r, sp2_r, tp2_r;
  logic [TH_W-1:0] low2_r, high2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      m2_r    <= m_nxt;
      sp2_r   <= sp_nxt;
      tp2_r   <= temp1_r;
      low2_r  <= chroma1_r ? chroma_low_r  : luma_low_r;
      high2_r <= chroma1_r ? chroma_high_r : luma_high_r;
    end
  end

  // Stage 3: blend weights; pure cases become weight one over one
  logic [TH_W-1:0] mw;
  logic [TH_W-1:0] w1_nxt, w2_nxt, den_nxt;

  always_comb begin
    mw = TH_W'(m2_r);
    if (mw < low2_r) begin
      w1_nxt  = '0;
      w2_nxt  = TH_W'(1);
      den_nxt = TH_W'(1);
    end else if (mw >= high2_r) begin
      w1_nxt  = TH_W'(1);
      w2_nxt  = '0;
      den_nxt = TH_W'(1);
    end else begin
      w1_nxt  = mw - low2_r;
      w2_nxt  = high2_r - mw;
      den_nxt = high2_r - low2_r;
    end
  end

  logic            v3_r;
  logic [TH_W-1:0] w1_3_r, w2_3_r, den3_r;
  logic [P-1:0]    sp3_r, tp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      w1_3_r <= w1_nxt;
      w2_3_r <= w2_nxt;
      den3_r <= den_nxt;
      sp3_r  <= sp2_r;
      tp3_r  <= tp2_r;
    end
  end

  // Stage 4: weighted products
  logic             v4_r;
  logic [NUM_W-1:0] p1_4_r, p2_4_r;
  logic [TH_W-1:0]  den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      p1_4_r <= NUM_W'(w1_3_r) * NUM_W'(sp3_r);
      p2_4_r <= NUM_W'(w2_3_r) * NUM_W'(tp3_r);
      den4_r <= den3_r;
    end
  end

  // Stage 5: numerator
  logic             v5_r;
  logic [NUM_W-1:0] num5_r;
  logic [TH_W-1:0]  den5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      num5_r <= p1_4_r + p2_4_r;
      den5_r <= den4_r;
    end
  end

  madp_pkg::div_ctrl_t div_ctrl;
  assign div_ctrl.valid = v5_r;
  assign div_ctrl.en    = en;

  madp_div #(
    .QW(P),
    .DW(TH_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .in_num    (num5_r),
    .in_den    (den5_r),
    .out_valid (div_valid),
    .out_quot  (div_quot)
  );

  assign out_valid = div_valid;
  assign out_pixel = 16'(div_quot);

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (den3_r != '0))
    else $error("blend denominator is zero");

  a_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ((TH_W+1)'(w1_3_r) + (TH_W+1)'(w2_3_r) == (TH_W+1)'(den3_r)))
    else $error("blend weights do not add up to the denominator");

  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (num5_r[NUM_W-1:P] < den5_r))
    else $error("quotient overflows pixel width");

endmodule

// ===== rtl/core/madp_div.sv =====
module madp_div #(
  parameter int QW = 16,
  parameter int DW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  madp_pkg::div_ctrl_t   ctrl,
  input  logic [DW+QW-1:0]      in_num,
  input  logic [DW-1:0]         in_den,
  output logic                  out_valid,
  output logic [QW-1:0]         out_quot
);

  logic [DW+QW-1:0] x_r   [QW];
  logic [DW-1:0]    den_r [QW];
  logic             v_r   [QW];

  // One quotient bit per stage, restoring form; upper part is the remainder.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW+QW-1:0] x_in;
    logic [DW-1:0]    d_in;
    logic             v_in;
    logic [DW:0]      r2;
    logic [DW:0]      diff;
    logic             ge;
    logic [DW+QW-1:0] x_nxt;

    if (k == 0) begin : g_first
      assign x_in = in_num;
      assign d_in = in_den;
      assign v_in = ctrl.valid;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign d_in = den_r[k-1];
      assign v_in = v_r[k-1];
    end

    always_comb begin
      r2    = {x_in[DW+QW-1:QW], x_in[QW-1]};
      diff  = r2 - {1'b0, d_in};
      ge    = (r2 >= {1'b0, d_in});
      x_nxt = {(ge ? diff[DW-1:0] : r2[DW-1:0]), x_in[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctrl.en) begin
        v_r[k] <= v_in;
      end
      if (ctrl.en) begin
        x_r[k]   <= x_nxt;
        den_r[k] <= d_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot  = x_r[QW-1][QW-1:0];

endmodule
